>>> rtl/cbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the CRC32C Bloom filter
// Item structs, controller/datapath command and status, CRC32C matrix.
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam int MAX_INDEX_BITS_DEF = 16;
	localparam int CFG_BITS           = 5;
	localparam int COUNT_BITS         = 17;
	localparam int PROBE_BITS         = 3;
	localparam int NUM_HASHES         = 7;

	localparam logic [CFG_BITS-1:0] INDEX_BITS_RST = CFG_BITS'(16);

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

	// low words of the four 64-bit seed primes
	localparam logic [31:0] SEED_1 = 32'h85EB_CA87;
	localparam logic [31:0] SEED_2 = 32'h27D4_EB4F;
	localparam logic [31:0] SEED_3 = 32'h9E37_79F9;
	localparam logic [31:0] SEED_4 = 32'hC2B2_AE63;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// hash select codes
	localparam logic [2:0] HSEL_1 = 3'd0;
	localparam logic [2:0] HSEL_2 = 3'd1;
	localparam logic [2:0] HSEL_3 = 3'd2;
	localparam logic [2:0] HSEL_4 = 3'd3;
	localparam logic [2:0] HSEL_5 = 3'd4;
	localparam logic [2:0] HSEL_6 = 3'd5;
	localparam logic [2:0] HSEL_7 = 3'd6;

	typedef struct packed {
		logic        kind;
		logic [63:0] key_low;
		logic [63:0] key_high;
	} in_item_t;

	typedef struct packed {
		logic                  present;
		logic [PROBE_BITS-1:0] probes;
		logic [COUNT_BITS-1:0] set_count;
	} out_item_t;

	typedef struct packed {
		logic       load;      // latch key and mask
		logic       issue;     // start one hash probe
		logic [2:0] sel;       // which hash
		logic       clear_en;  // clear one store bit
		logic       out_load;  // capture result
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic probe_valid;
		logic probe_last;
		logic probe_clear;
		logic kind;
	} dp_status_t;

	typedef logic [31:0][31:0] crc_cols_t;

	// CRC of a single set bit, evaluated at elaboration only
	function automatic crc_cols_t crc_cols_f();
		crc_cols_t   cols;
		logic [31:0] c;
		for (int j = 0; j < 32; j++) begin
			c = 32'h1 << j;
			for (int k = 0; k < 32; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			cols[j] = c;
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_cols_f();

	// raw 32-bit CRC32C step as a linear map: XOR of the columns of set bits
	function automatic logic [31:0] crc32c_f(input logic [31:0] seed, input logic [31:0] word);
		logic [31:0] x;
		logic [31:0] acc;
		x   = seed ^ word;
		acc = '0;
		for (int j = 0; j < 32; j++) begin
			acc = acc ^ ({32{x[j]}} & CRC_COLS[j]);
		end
		return acc;
	endfunction

endpackage

>>> rtl/cbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_ctrl: Bloom filter sequencer
// Runs the clearing pass, issues up to seven probes per key and hands off results.
// ----------------------------------------------------------------------------
module cbf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  cbf_pkg::dp_status_t status,
	output cbf_pkg::ctl_cmd_t   cmd
);
	import cbf_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic       accept;
	logic       issue;
	logic       finish;
	logic       out_load;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign issue    = (state_q == ST_RUN) && (cnt_q != 3'(NUM_HASHES));
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign finish   = status.probe_valid &&
		(status.probe_last || (status.kind == KIND_QUERY && status.probe_clear));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (status.clear_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_RUN;
			ST_RUN:   if (finish) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.issue    = issue;
		cmd.sel      = cnt_q;
		cmd.clear_en = (state_q == ST_CLEAR);
		cmd.out_load = out_load;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/cbf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_datapath: hash, bit store and counters of the Bloom filter
// Three-step probe pipe: hash index, store read, check and set.
// ----------------------------------------------------------------------------
module cbf_datapath #(
	parameter int MAX_INDEX_BITS = cbf_pkg::MAX_INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbf_pkg::in_item_t              in_data,
	input  logic                           cfg_wr_en,
	input  logic [cbf_pkg::CFG_BITS-1:0]   cfg_wr_data,
	input  cbf_pkg::ctl_cmd_t              cmd,
	output cbf_pkg::dp_status_t            status,
	output cbf_pkg::out_item_t             out_data
);
	import cbf_pkg::*;

	localparam int AW = MAX_INDEX_BITS;

	logic                  mem [2**AW];

	logic [CFG_BITS-1:0]   index_bits_q;
	logic [AW-1:0]         clr_addr_q;
	logic [31:0]           w0_q, w1_q, w2_q, w3_q;
	logic                  kind_q;
	logic [AW-1:0]         mask_q;
	logic [AW-1:0]         mask_d;
	logic [5:0]            eff_bits;

	logic [31:0]           seed;
	logic [31:0]           word;
	logic [31:0]           crc;

	logic [AW-1:0]         idx_s1;
	logic                  valid_s1;
	logic                  last_s1;
	logic [AW-1:0]         idx_s2;
	logic                  valid_s2;
	logic                  last_s2;
	logic                  rbit_s2;

	logic [AW-1:0]         prev_idx_q;
	logic                  prev_v_q;
	logic                  hit;
	logic                  set_bit;
	logic                  miss_q;
	logic [PROBE_BITS-1:0] probes_q;
	logic [COUNT_BITS-1:0] ones_q;
	out_item_t             out_q;

	// saturate the index width and build the mask
	always_comb begin
		eff_bits = (6'(index_bits_q) > 6'(MAX_INDEX_BITS)) ?
			6'(MAX_INDEX_BITS) : 6'(index_bits_q);
		for (int j = 0; j < AW; j++) begin
			mask_d[j] = (6'(j) < eff_bits);
		end
	end

	always_comb begin
		case (cmd.sel)
			HSEL_1:  begin seed = SEED_1; word = w0_q; end
			HSEL_2:  begin seed = SEED_2; word = w1_q; end
			HSEL_3:  begin seed = SEED_3; word = w2_q; end
			HSEL_4:  begin seed = SEED_4; word = w3_q; end
			HSEL_5:  begin seed = w3_q;   word = w1_q; end
			HSEL_6:  begin seed = w0_q;   word = w1_q; end
			HSEL_7:  begin seed = w2_q;   word = w3_q; end
			default: begin seed = '0;     word = '0;   end
		endcase
		crc = crc32c_f(seed, word);
	end

	// the read of a probe misses the write of the probe right before it
	assign hit     = rbit_s2 || (prev_v_q && (prev_idx_q == idx_s2));
	assign set_bit = valid_s2 && (kind_q == KIND_ADD) && !hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= INDEX_BITS_RST;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			prev_v_q     <= 1'b0;
			miss_q       <= 1'b0;
			probes_q     <= '0;
			ones_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				index_bits_q <= cfg_wr_data;
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.load) begin
				valid_s1 <= 1'b0;
				valid_s2 <= 1'b0;
				prev_v_q <= 1'b0;
				miss_q   <= 1'b0;
				probes_q <= '0;
			end else begin
				valid_s1 <= cmd.issue;
				valid_s2 <= valid_s1;
				if (valid_s2) begin
					prev_v_q <= 1'b1;
				end
				// count query probes up to and including the first clear bit
				if (valid_s2 && kind_q == KIND_QUERY && !miss_q) begin
					probes_q <= probes_q + PROBE_BITS'(1);
					if (!hit) begin
						miss_q <= 1'b1;
					end
				end
			end
			if (set_bit) begin
				ones_q <= ones_q + COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w0_q   <= in_data.key_low[31:0];
			w1_q   <= in_data.key_low[63:32];
			w2_q   <= in_data.key_high[31:0];
			w3_q   <= in_data.key_high[63:32];
			kind_q <= in_data.kind;
			mask_q <= mask_d;
		end
		idx_s1     <= crc[AW-1:0] & mask_q;
		last_s1    <= (cmd.sel == HSEL_7);
		idx_s2     <= idx_s1;
		last_s2    <= last_s1;
		prev_idx_q <= idx_s2;
		if (cmd.out_load) begin
			out_q.present   <= (kind_q == KIND_QUERY) && !miss_q;
			out_q.probes    <= probes_q;
			out_q.set_count <= ones_q;
		end
	end

	// bit store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (set_bit) begin
			mem[idx_s2] <= 1'b1;
		end
		rbit_s2 <= mem[idx_s1];
	end

	always_comb begin
		status             = '0;
		status.clear_last  = &clr_addr_q;
		status.probe_valid = valid_s2;
		status.probe_last  = last_s2;
		status.probe_clear = !hit;
		status.kind        = kind_q;
	end

	assign out_data = out_q;

endmodule

>>> rtl/crc32c_bloom_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_bloom_filter: Bloom filter over 128-bit keys with CRC32C indices
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data  (kind, key_low, key_high)
// out      output     out_valid / out_stall out_data (present, probes, set_count)
// cfg      input      cfg_wr_en             cfg_wr_data (index_bits)
//
// An add runs all seven probes; a query stops at the first probe that finds a
// clear bit. Probes share the single write port and one read port of the bit
// memory. A new key is taken only once the last result is in the output
// register. After reset a clearing pass over all 2**MAX_INDEX_BITS store bits
// runs before the first input transfer. A stalled result holds in the output
// register while the next key is already taken.
// ----------------------------------------------------------------------------
module crc32c_bloom_filter #(
	parameter int MAX_INDEX_BITS = cbf_pkg::MAX_INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cbf_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cbf_pkg::out_item_t           out_data,
	input  logic                         cfg_wr_en,
	input  logic [cbf_pkg::CFG_BITS-1:0] cfg_wr_data
);
	import cbf_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	cbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	cbf_datapath #(
		.MAX_INDEX_BITS (MAX_INDEX_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_data    (out_data)
	);

endmodule
